### src/igsa_pkg.sv
// ----------------------------------------------------------------------------
// igsa_pkg
// Shared constants, register codes and types of the integer GEMM engine.
// ----------------------------------------------------------------------------
package igsa_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int DEF_MAX_DIM = 8;
   localparam int IDX_W       = 3;
   localparam int DIM_W       = 4;
   localparam int OP_W        = 2;
   localparam int PADDR_W     = 5;
   localparam int PDATA_W     = 32;
   localparam int REG_IDX_W   = 3;

   localparam logic [OP_W-1:0] OP_LOAD_A   = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD_ADD = 2'd2;
   localparam logic [OP_W-1:0] OP_START    = 2'd3;

   localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_INNER_DIM  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_NUM_COLS   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SCALE_S    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SCALE_L    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_USE_ADDEND = 3'd5;

   localparam logic [DIM_W-1:0]      RST_DIM   = 4'd8;
   localparam logic [DATA_WIDTH-1:0] RST_SCALE = 32'd1;

   typedef struct packed {
      logic [DIM_W-1:0]      num_rows;
      logic [DIM_W-1:0]      inner_dim;
      logic [DIM_W-1:0]      num_cols;
      logic [DATA_WIDTH-1:0] scale_s;
      logic [DATA_WIDTH-1:0] scale_l;
      logic                  use_addend;
   } cfg_type;

   typedef struct packed {
      logic                  load_en;
      logic [OP_W-1:0]       load_op;
      logic [IDX_W-1:0]      load_row;
      logic [IDX_W-1:0]      load_col;
      logic [DATA_WIDTH-1:0] load_value;
      logic                  rd_en;
      logic                  rd_add;
      logic                  first;
      logic                  last_step;
      logic                  scale_en;
      logic                  emit_en;
      logic                  emit_last;
      logic [IDX_W-1:0]      i;
      logic [IDX_W-1:0]      j;
      logic [IDX_W-1:0]      k;
   } cmd_type;

   typedef struct packed {
      logic acc_done;
      logic out_free;
   } status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                  input logic [DIM_W-1:0] cap);
      logic [DIM_W-1:0] r;
      r = d;
      if (r == '0) begin
         r = 4'd1;
      end
      if (r > cap) begin
         r = cap;
      end
      return r;
   endfunction

endpackage

### src/igsa_if.sv
// ----------------------------------------------------------------------------
// igsa_if
// Request and response channels of the integer GEMM engine.
// ----------------------------------------------------------------------------
interface igsa_req_if import igsa_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              op;
   logic [IDX_W-1:0]             row;
   logic [IDX_W-1:0]             col;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, output op, output row, output col, output value,
                   input ready);
   modport sink (input valid, input op, input row, input col, input value,
                 output ready);
endinterface

interface igsa_rsp_if import igsa_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [IDX_W-1:0]             out_row;
   logic [IDX_W-1:0]             out_col;
   logic signed [DATA_WIDTH-1:0] result;
   logic                         last;

   modport source (output valid, output out_row, output out_col, output result,
                   output last, input ready);
   modport sink (input valid, input out_row, input out_col, input result,
                 input last, output ready);
endinterface

### src/integer_gemm_scale_add.sv
// Load requests: one per cycle while idle, no response.
// Start request: each result element takes one store read per inner step (and
// an addend read when enabled) through the shared 32x32 multiplier, a drain,
// the scale multiply and the output register; a run is rows*cols elements.
// Synchronous reset clears the sequencer, pipeline flags, output valid and the
// registers to their defaults; the A, B and addend stores hold unknown data.
// ----------------------------------------------------------------------------
// integer_gemm_scale_add
// Integer GEMM engine computing s*(A*B + l*C) element by element.
// ----------------------------------------------------------------------------
module integer_gemm_scale_add import igsa_pkg::*; #(
   parameter int MAX_DIM = DEF_MAX_DIM
) (
   input  logic               clock,
   input  logic               reset,
   igsa_req_if.sink           req_if,
   igsa_rsp_if.source         rsp_if,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   igsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   igsa_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .cfg    (cfg),
      .status (status),
      .cmd    (cmd)
   );

   igsa_dpath #(.MAX_DIM(MAX_DIM)) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .cmd    (cmd),
      .status (status),
      .rsp_if (rsp_if)
   );

endmodule

### src/igsa_ram.sv
// ----------------------------------------------------------------------------
// igsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module igsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/igsa_csr.sv
// ----------------------------------------------------------------------------
// igsa_csr
// APB register file: matrix dimensions, scale factors and addend enable.
// ----------------------------------------------------------------------------
module igsa_csr import igsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign reg_idx = paddr[PADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_NUM_ROWS:   cfg_in.num_rows   = pwdata[DIM_W-1:0];
            REG_INNER_DIM:  cfg_in.inner_dim  = pwdata[DIM_W-1:0];
            REG_NUM_COLS:   cfg_in.num_cols   = pwdata[DIM_W-1:0];
            REG_SCALE_S:    cfg_in.scale_s    = pwdata[DATA_WIDTH-1:0];
            REG_SCALE_L:    cfg_in.scale_l    = pwdata[DATA_WIDTH-1:0];
            REG_USE_ADDEND: cfg_in.use_addend = pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_NUM_ROWS:   prdata = PDATA_W'(cfg_ff.num_rows);
         REG_INNER_DIM:  prdata = PDATA_W'(cfg_ff.inner_dim);
         REG_NUM_COLS:   prdata = PDATA_W'(cfg_ff.num_cols);
         REG_SCALE_S:    prdata = PDATA_W'(cfg_ff.scale_s);
         REG_SCALE_L:    prdata = PDATA_W'(cfg_ff.scale_l);
         REG_USE_ADDEND: prdata = PDATA_W'(cfg_ff.use_addend);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_rows   <= RST_DIM;
         cfg_ff.inner_dim  <= RST_DIM;
         cfg_ff.num_cols   <= RST_DIM;
         cfg_ff.scale_s    <= RST_SCALE;
         cfg_ff.scale_l    <= RST_SCALE;
         cfg_ff.use_addend <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/igsa_ctrl.sv
// ----------------------------------------------------------------------------
// igsa_ctrl
// Sequencer: accepts loads, walks rows, columns and the inner sum on start.
// ----------------------------------------------------------------------------
module igsa_ctrl import igsa_pkg::*; #(
   parameter int MAX_DIM = DEF_MAX_DIM
) (
   input  logic       clock,
   input  logic       reset,
   igsa_req_if.sink   req_if,
   input  cfg_type    cfg,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int DimCap = (MAX_DIM < 8) ? MAX_DIM : 8;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAC   = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_SCALE = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [DIM_W-1:0] nr, nk, nc;
   logic [IDX_W-1:0] nr_m1, nk_m1, nc_m1;
   logic             req_ready;
   logic             last_elem;

   assign nr    = clamp_dim(cfg.num_rows, DIM_W'(DimCap));
   assign nk    = clamp_dim(cfg.inner_dim, DIM_W'(DimCap));
   assign nc    = clamp_dim(cfg.num_cols, DIM_W'(DimCap));
   assign nr_m1 = IDX_W'(nr - 4'd1);
   assign nk_m1 = IDX_W'(nk - 4'd1);
   assign nc_m1 = IDX_W'(nc - 4'd1);
   assign last_elem = (i_ff == nr_m1) && (j_ff == nc_m1);

   always_comb begin
      state_in       = state_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.load_op    = req_if.op;
      cmd.load_row   = req_if.row;
      cmd.load_col   = req_if.col;
      cmd.load_value = req_if.value;
      cmd.i          = i_ff;
      cmd.j          = j_ff;
      cmd.k          = k_ff;
      cmd.emit_last  = last_elem;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               if (req_if.op == OP_START) begin
                  state_in = ST_MAC;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
               end else begin
                  cmd.load_en = 1'b1;
               end
            end
         end
         ST_MAC: begin
            cmd.rd_en     = 1'b1;
            cmd.first     = (k_ff == '0);
            cmd.last_step = (k_ff == nk_m1) && !cfg.use_addend;
            if (k_ff == nk_m1) begin
               k_in     = '0;
               state_in = cfg.use_addend ? ST_ADD : ST_WAIT;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         ST_ADD: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_add    = 1'b1;
            cmd.last_step = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.acc_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale_en = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_en = 1'b1;
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MAC;
                  if (j_ff == nc_m1) begin
                     j_in = '0;
                     i_in = i_ff + 3'd1;
                  end else begin
                     j_in = j_ff + 3'd1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_if.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.acc_done |-> state_ff == ST_WAIT)
      else $error("accumulator finished outside of wait state");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_en |-> status.out_free)
      else $error("result emitted into a busy output register");

endmodule

### src/igsa_dpath.sv
// ----------------------------------------------------------------------------
// igsa_dpath
// Element stores, shared multiplier, accumulator and response register.
// ----------------------------------------------------------------------------
module igsa_dpath import igsa_pkg::*; #(
   parameter int MAX_DIM = DEF_MAX_DIM
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   output status_type  status,
   igsa_rsp_if.source  rsp_if
);

   localparam int Depth = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(Depth);

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic add;
   } stage_type;

   stage_type             s1_ff, s2_ff;
   logic [AW-1:0]         wr_addr, rd_addr_a, rd_addr_b, rd_addr_c;
   logic                  in_range;
   logic                  wr_a, wr_b, wr_c;
   logic                  rd_ab, rd_c;
   logic [DATA_WIDTH-1:0] a_data, b_data, c_data;
   logic [DATA_WIDTH-1:0] mul_x, mul_y, prod;
   logic [DATA_WIDTH-1:0] p_ff, acc_ff;
   logic                  rsp_valid_ff;
   logic [IDX_W-1:0]      rsp_row_ff, rsp_col_ff;
   logic [DATA_WIDTH-1:0] rsp_result_ff;
   logic                  rsp_last_ff;

   assign in_range  = (int'(cmd.load_row) < MAX_DIM) && (int'(cmd.load_col) < MAX_DIM);
   assign wr_addr   = AW'(int'(cmd.load_row) * MAX_DIM + int'(cmd.load_col));
   assign rd_addr_a = AW'(int'(cmd.i) * MAX_DIM + int'(cmd.k));
   assign rd_addr_b = AW'(int'(cmd.k) * MAX_DIM + int'(cmd.j));
   assign rd_addr_c = AW'(int'(cmd.i) * MAX_DIM + int'(cmd.j));

   assign wr_a  = cmd.load_en && in_range && (cmd.load_op == OP_LOAD_A);
   assign wr_b  = cmd.load_en && in_range && (cmd.load_op == OP_LOAD_B);
   assign wr_c  = cmd.load_en && in_range && (cmd.load_op == OP_LOAD_ADD);
   assign rd_ab = cmd.rd_en && !cmd.rd_add;
   assign rd_c  = cmd.rd_en && cmd.rd_add;

   igsa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(Depth)) u_a_ram (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (cmd.load_value),
      .rd_en   (rd_ab),
      .rd_addr (rd_addr_a),
      .rd_data (a_data)
   );

   igsa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(Depth)) u_b_ram (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (cmd.load_value),
      .rd_en   (rd_ab),
      .rd_addr (rd_addr_b),
      .rd_data (b_data)
   );

   igsa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(Depth)) u_c_ram (
      .clock   (clock),
      .wr_en   (wr_c),
      .wr_addr (wr_addr),
      .wr_data (cmd.load_value),
      .rd_en   (rd_c),
      .rd_addr (rd_addr_c),
      .rd_data (c_data)
   );

   always_comb begin
      if (cmd.scale_en) begin
         mul_x = cfg.scale_s;
         mul_y = acc_ff;
      end else if (s1_ff.add) begin
         mul_x = cfg.scale_l;
         mul_y = c_data;
      end else begin
         mul_x = a_data;
         mul_y = b_data;
      end
   end

   assign prod = mul_x * mul_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff.valid <= cmd.rd_en;
         s1_ff.first <= cmd.first;
         s1_ff.last  <= cmd.last_step;
         s1_ff.add   <= cmd.rd_add;
         s2_ff.valid <= s1_ff.valid;
         s2_ff.first <= s1_ff.first;
         s2_ff.last  <= s1_ff.last;
         s2_ff.add   <= s1_ff.add;
         if (cmd.emit_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ff.valid || cmd.scale_en) begin
         p_ff <= prod;
      end
      if (s2_ff.valid) begin
         acc_ff <= s2_ff.first ? p_ff : acc_ff + p_ff;
      end
      if (cmd.emit_en) begin
         rsp_row_ff    <= cmd.i;
         rsp_col_ff    <= cmd.j;
         rsp_result_ff <= p_ff;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign status.acc_done = s2_ff.valid && s2_ff.last;
   assign status.out_free = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.out_row = rsp_row_ff;
   assign rsp_if.out_col = rsp_col_ff;
   assign rsp_if.result  = rsp_result_ff;
   assign rsp_if.last    = rsp_last_ff;

   a_scale_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.scale_en |-> !s1_ff.valid && !s2_ff.valid)
      else $error("scale step overlaps the product pipeline");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en |-> !cmd.rd_en && !s1_ff.valid && !s2_ff.valid)
      else $error("store write during a run");

   a_done_then_scale: assert property (@(posedge clock) disable iff (reset)
      status.acc_done |=> cmd.scale_en)
      else $error("scale step did not follow the last accumulate");

endmodule

### sim/integer_gemm_scale_add_check.sv
// ----------------------------------------------------------------------------
// integer_gemm_scale_add_check
// Watches the request, response and register ports of the GEMM engine, keeps
// its own copy of the A, B and addend stores and of the registers, computes
// every product element on each start request and compares the responses in
// order, field by field.
// ----------------------------------------------------------------------------
module integer_gemm_scale_add_check import igsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   igsa_req_if                req,
   igsa_rsp_if                rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = DEF_MAX_DIM * DEF_MAX_DIM;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [IDX_W-1:0]      row;
      logic [IDX_W-1:0]      col;
      logic [DATA_WIDTH-1:0] value;
      logic                  last;
   } product_elem_type;

   logic [DATA_WIDTH-1:0] a_mem [STORE_DEPTH];
   logic [DATA_WIDTH-1:0] b_mem [STORE_DEPTH];
   logic [DATA_WIDTH-1:0] add_mem [STORE_DEPTH];
   cfg_type               cfg;
   product_elem_type      product_q [$];

   function automatic int dim_span(input logic [DIM_W-1:0] d);
      if (d == '0) begin
         return 1;
      end
      if (d > DEF_MAX_DIM) begin
         return DEF_MAX_DIM;
      end
      return int'(d);
   endfunction

   task automatic predict_product();
      int                    rows;
      int                    inner;
      int                    cols;
      logic [DATA_WIDTH-1:0] acc;
      product_elem_type      elem;
      rows  = dim_span(cfg.num_rows);
      inner = dim_span(cfg.inner_dim);
      cols  = dim_span(cfg.num_cols);
      for (int i = 0; i < rows; i++) begin
         for (int j = 0; j < cols; j++) begin
            acc = '0;
            for (int k = 0; k < inner; k++) begin
               acc = acc + a_mem[i*DEF_MAX_DIM + k] * b_mem[k*DEF_MAX_DIM + j];
            end
            if (cfg.use_addend) begin
               acc = acc + cfg.scale_l * add_mem[i*DEF_MAX_DIM + j];
            end
            acc = cfg.scale_s * acc;
            elem.row   = IDX_W'(i);
            elem.col   = IDX_W'(j);
            elem.value = acc;
            elem.last  = (i == rows - 1) && (j == cols - 1);
            product_q.push_back(elem);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      product_elem_type seen;
      product_elem_type want;
      if (reset) begin
         cfg.num_rows   = RST_DIM;
         cfg.inner_dim  = RST_DIM;
         cfg.num_cols   = RST_DIM;
         cfg.scale_s    = RST_SCALE;
         cfg.scale_l    = RST_SCALE;
         cfg.use_addend = 1'b0;
         product_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            seen = {rsp.out_row, rsp.out_col, rsp.result, rsp.last};
            if (product_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("unexpected response: row %0d col %0d result %0d last %0b",
                           seen.row, seen.col, $signed(seen.value), seen.last);
               end
            end else begin
               want = product_q.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("mismatch: expected row %0d col %0d result %0d last %0b",
                              want.row, want.col, $signed(want.value), want.last);
                     $display("          actual   row %0d col %0d result %0d last %0b",
                              seen.row, seen.col, $signed(seen.value), seen.last);
                  end
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[PADDR_W-1:2])
               REG_NUM_ROWS:   cfg.num_rows   = pwdata[DIM_W-1:0];
               REG_INNER_DIM:  cfg.inner_dim  = pwdata[DIM_W-1:0];
               REG_NUM_COLS:   cfg.num_cols   = pwdata[DIM_W-1:0];
               REG_SCALE_S:    cfg.scale_s    = pwdata[DATA_WIDTH-1:0];
               REG_SCALE_L:    cfg.scale_l    = pwdata[DATA_WIDTH-1:0];
               REG_USE_ADDEND: cfg.use_addend = pwdata[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            case (req.op)
               OP_LOAD_A:   a_mem[{req.row, req.col}]   = req.value;
               OP_LOAD_B:   b_mem[{req.row, req.col}]   = req.value;
               OP_LOAD_ADD: add_mem[{req.row, req.col}] = req.value;
               OP_START:    predict_product();
               default: ;
            endcase
         end
      end
      pending <= product_q.size();
   end

endmodule

### sim/integer_gemm_scale_add_test.sv
// ----------------------------------------------------------------------------
// integer_gemm_scale_add_test
// Drives load and start requests and register writes into the GEMM engine
// with random gaps and response stalls, one long response hold-off included;
// the checker beside the block predicts and compares every product element.
// ----------------------------------------------------------------------------
module integer_gemm_scale_add_test;
   timeunit 1ns;
   timeprecision 1ps;

   import igsa_pkg::*;

   localparam int RESET_CYCLES     = 9;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PRESSURE_AFTER   = 40;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int RANDOM_ITEMS     = 130;

   logic               clock = 1'b0;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;
   int                 fail_count;
   int                 pending;

   logic [DIM_W-1:0]   rows_reg;
   logic [DIM_W-1:0]   inner_reg;
   logic [DIM_W-1:0]   cols_reg;
   logic               use_add_reg;
   bit [63:0]          a_set;
   bit [63:0]          b_set;
   bit [63:0]          add_set;
   int                 items_sent;
   int                 req_burst_left;

   igsa_req_if req_ch ();
   igsa_rsp_if rsp_ch ();

   integer_gemm_scale_add dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   integer_gemm_scale_add_check product_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   function automatic int eff_dim(input logic [DIM_W-1:0] d);
      if (d == '0) begin
         return 1;
      end
      return (d > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(d);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return DIM_W'($urandom_range(8, 15));
         default: return DIM_W'($urandom_range(1, 3));
      endcase
   endfunction

   function automatic int request_gap();
      if (req_burst_left > 0) begin
         req_burst_left--;
         return 0;
      end
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            req_burst_left = $urandom_range(4, 30);
            return 0;
         end
         3: return $urandom_range(8, 40);
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col,
                               input logic [DATA_WIDTH-1:0] value);
      int gap;
      gap = request_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.row   <= row;
      req_ch.col   <= col;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
      if (op == OP_LOAD_A) begin
         a_set[{row, col}] = 1'b1;
      end else if (op == OP_LOAD_B) begin
         b_set[{row, col}] = 1'b1;
      end else if (op == OP_LOAD_ADD) begin
         add_set[{row, col}] = 1'b1;
      end
      items_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                            input logic [DIM_W-1:0] cols, input logic [DATA_WIDTH-1:0] s,
                            input logic [DATA_WIDTH-1:0] l, input logic use_add);
      drain();
      write_reg(REG_NUM_ROWS, PDATA_W'({$urandom, rows}));
      write_reg(REG_INNER_DIM, PDATA_W'(inner));
      write_reg(REG_NUM_COLS, PDATA_W'(cols));
      write_reg(REG_SCALE_S, s);
      write_reg(REG_SCALE_L, l);
      write_reg(REG_USE_ADDEND, PDATA_W'(use_add));
      rows_reg    = rows;
      inner_reg   = inner;
      cols_reg    = cols;
      use_add_reg = use_add;
   endtask

   // write every element the next product reads that holds no value yet, then start
   task automatic run_product();
      int rows;
      int inner;
      int cols;
      rows  = eff_dim(rows_reg);
      inner = eff_dim(inner_reg);
      cols  = eff_dim(cols_reg);
      for (int i = 0; i < rows; i++) begin
         for (int k = 0; k < inner; k++) begin
            if (!a_set[i*DEF_MAX_DIM + k]) begin
               send_request(OP_LOAD_A, IDX_W'(i), IDX_W'(k), pick_value());
            end
         end
      end
      for (int k = 0; k < inner; k++) begin
         for (int j = 0; j < cols; j++) begin
            if (!b_set[k*DEF_MAX_DIM + j]) begin
               send_request(OP_LOAD_B, IDX_W'(k), IDX_W'(j), pick_value());
            end
         end
      end
      if (use_add_reg) begin
         for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
               if (!add_set[i*DEF_MAX_DIM + j]) begin
                  send_request(OP_LOAD_ADD, IDX_W'(i), IDX_W'(j), pick_value());
               end
            end
         end
      end
      send_request(OP_START, IDX_W'($urandom), IDX_W'($urandom), $urandom);
   endtask

   initial begin
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_LOAD_A;
      req_ch.row     = '0;
      req_ch.col     = '0;
      req_ch.value   = '0;
      rows_reg       = RST_DIM;
      inner_reg      = RST_DIM;
      cols_reg       = RST_DIM;
      use_add_reg    = 1'b0;
      a_set          = '0;
      b_set          = '0;
      add_set        = '0;
      items_sent     = 0;
      req_burst_left = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      configure(4'd2, 4'd2, 4'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      send_request(OP_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
      send_request(OP_LOAD_A, 3'd0, 3'd1, 32'h7FFF_FFFF);
      send_request(OP_LOAD_A, 3'd1, 3'd0, 32'hFFFF_FFFF);
      send_request(OP_LOAD_A, 3'd1, 3'd1, 32'h0000_0000);
      send_request(OP_LOAD_B, 3'd0, 3'd0, 32'hFFFF_FFFF);
      send_request(OP_LOAD_B, 3'd0, 3'd1, 32'h8000_0000);
      send_request(OP_LOAD_B, 3'd1, 3'd0, 32'h7FFF_FFFF);
      send_request(OP_LOAD_B, 3'd1, 3'd1, 32'h0000_0001);
      send_request(OP_LOAD_ADD, 3'd0, 3'd0, 32'h8000_0000);
      send_request(OP_LOAD_ADD, 3'd0, 3'd1, 32'h7FFF_FFFF);
      send_request(OP_LOAD_ADD, 3'd1, 3'd0, 32'h0000_0001);
      send_request(OP_LOAD_ADD, 3'd1, 3'd1, 32'h0000_0000);
      send_request(OP_LOAD_A, 3'd7, 3'd7, pick_value());
      send_request(OP_LOAD_B, 3'd7, 3'd7, pick_value());
      send_request(OP_LOAD_ADD, 3'd7, 3'd7, pick_value());
      // start ignores its index and value fields
      send_request(OP_START, 3'd7, 3'd7, 32'hFFFF_FFFF);
      // rows saturate, zero inner dimension counts as one, addend off
      configure(4'd15, 4'd0, 4'd1, 32'h8000_0000, 32'h8000_0000, 1'b0);
      run_product();

      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) begin
            configure(pick_dim(), pick_dim(), pick_dim(), pick_value(), pick_value(),
                      1'($urandom_range(0, 1)));
         end
         repeat ($urandom_range(0, 3)) begin
            send_request(OP_W'($urandom_range(0, 2)), IDX_W'($urandom), IDX_W'($urandom),
                         pick_value());
         end
         run_product();
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // response side: free runs, short and long stalls, and one long hold-off mid-run
   initial begin
      int hold_left;
      int run_left;
      int taken;
      bit pressure_done;
      hold_left     = 0;
      run_left      = 0;
      taken         = 0;
      pressure_done = 1'b0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            taken++;
         end
         if (!pressure_done && taken >= PRESSURE_AFTER && rsp_ch.valid &&
             req_ch.valid && !req_ch.ready) begin
            pressure_done = 1'b1;
            hold_left     = LONG_HOLD_CYCLES;
            run_left      = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_ch.ready <= 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  run_left = $urandom_range(10, 150);
                  rsp_ch.ready <= 1'b1;
               end
               5: begin
                  hold_left = $urandom_range(10, 60);
                  rsp_ch.ready <= 1'b0;
               end
               default: begin
                  hold_left = $urandom_range(0, 2);
                  rsp_ch.ready <= 1'b0;
               end
            endcase
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (psel && penable && pwrite && pready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("FAIL");
      $finish;
   end

endmodule
